// ===== rtl/i2c_reg16_transaction_master_assert.svh =====
// Assertion macros for the I2C 16-bit register transaction master.
// Clock aclk and active-low reset aresetn are assumed in the including scope.
`ifndef I2C_REG16_TRANSACTION_MASTER_ASSERT_SVH
`define I2C_REG16_TRANSACTION_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CR16_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define I2CR16_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define I2CR16_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2CR16_ASSERT(lbl, cond, msg)
`define I2CR16_ASSERT_IMPL(lbl, ante, cons, msg)
`define I2CR16_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/i2cr16_pkg.sv =====
// Shared types and constants for the I2C 16-bit register transaction master.
// No dependencies.
package i2cr16_pkg;

    localparam int PHASE_W = 4;
    localparam int BITCNT_W = 5;

    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_START   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_TX_WCMD = 4'd2;
    localparam logic [PHASE_W-1:0] PH_TX_AH   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_TX_AL   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_RESTART = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TX_RCMD = 4'd6;
    localparam logic [PHASE_W-1:0] PH_TX_DATA = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RX_DATA = 4'd8;
    localparam logic [PHASE_W-1:0] PH_STOP    = 4'd9;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_LOAD  = 2'd3;

    localparam logic CFG_WCMD = 1'b0;
    localparam logic CFG_RCMD = 1'b1;

    localparam logic [7:0] WCMD_RESET = 8'h28;
    localparam logic [7:0] RCMD_RESET = 8'h29;

    // write port of the data buffer
    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic [7:0] data;
    } wr_req_t;

endpackage

// ===== rtl/i2cr16_wbuf.sv =====
// Write data buffer: one write port, one prefetching registered read port.
// Depends on i2cr16_pkg.
module i2cr16_wbuf #(
    parameter int BUF_DEPTH = 16
) (
    input  logic                                aclk,
    input  i2cr16_pkg::wr_req_t                 wr,
    input  logic [$clog2(BUF_DEPTH + 1):0]      rd_ptr,
    output logic [7:0]                          rd_data
);

    localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0]       mem [BUF_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             wr_ok;
    logic             rd_ok;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    assign wr_ok   = wr.en && (32'(wr.idx) < BUF_DEPTH);
    assign rd_ok   = 32'(rd_ptr) < BUF_DEPTH;
    assign wr_addr = IDX_W'(wr.idx);
    assign rd_addr = rd_ptr[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // same-cycle write is forwarded so the prefetched byte is never stale
    always_ff @(posedge aclk) begin
        if (wr_ok && rd_ok && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else if (rd_ok) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2c_reg16_transaction_master.sv =====
// I2C master for register transactions with a 16-bit register address (top level).
// Each result is registered in the cycle after its transaction is accepted; throughput one transaction per cycle
// while m_ready drains the result slot, set by the single engine update between handshake and result register.
// Reset (aresetn, synchronous, active low): engine idle, lines released, command regs 0x28/0x29.
// Depends on i2cr16_pkg, i2cr16_wbuf and i2c_reg16_transaction_master_assert.svh.
`include "i2c_reg16_transaction_master_assert.svh"

module i2c_reg16_transaction_master #(
    parameter int BUF_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata,

    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_register_address,
    input  logic [7:0]  s_byte_count,
    input  logic [3:0]  s_load_index,
    input  logic [7:0]  s_load_value,
    input  logic        s_sda_sample,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_drive,
    output logic        m_read_valid,
    output logic [7:0]  m_read_value,
    output logic        m_read_last,
    output logic        m_engine_busy,
    output logic        m_transaction_done
);

    localparam int BIDX_W = $clog2(BUF_DEPTH + 1);
    localparam int PTR_W  = BIDX_W + 1;
    localparam int PW     = i2cr16_pkg::PHASE_W;
    localparam int CW     = i2cr16_pkg::BITCNT_W;

    // ---------------------------------------------------------------
    // Handshake: the result register is the skid stage. A new transaction
    // is taken whenever the result slot is empty or drains this cycle.
    // ---------------------------------------------------------------
    logic m_valid_reg;
    logic s_accept;
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // command registers
    logic [7:0] wcmd_reg;
    logic [7:0] rcmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcmd_reg <= i2cr16_pkg::WCMD_RESET;
            rcmd_reg <= i2cr16_pkg::RCMD_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == i2cr16_pkg::CFG_WCMD) begin
                wcmd_reg <= cfg_wdata;
            end
            if (cfg_index == i2cr16_pkg::CFG_RCMD) begin
                rcmd_reg <= cfg_wdata;
            end
        end
    end

    // ---------------------------------------------------------------
    // Engine state
    // ---------------------------------------------------------------
    logic [PW-1:0]     phase_reg, phase_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        left_reg, left_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic [15:0]       addr_reg, addr_next;
    logic              isrd_reg, isrd_next;
    logic              scl_reg, scl_next;
    logic              sda_reg, sda_next;

    logic              rvalid;
    logic [7:0]        rvalue;
    logic              rlast;
    logic              done;

    // ---------------------------------------------------------------
    // Write buffer. The read side prefetches the byte that the next
    // data segment would load: slot bidx while sending the address, slot
    // bidx+1 while a data byte is on the wire.
    // ---------------------------------------------------------------
    i2cr16_pkg::wr_req_t wr_req;
    logic [PTR_W-1:0]    rd_ptr;
    logic [7:0]          buf_byte;

    assign wr_req.en   = s_accept && (s_func == i2cr16_pkg::FUNC_LOAD);
    assign wr_req.idx  = s_load_index;
    assign wr_req.data = s_load_value;
    assign rd_ptr      = PTR_W'(bidx_reg)
                       + PTR_W'(phase_reg == i2cr16_pkg::PH_TX_DATA);

    i2cr16_wbuf #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_wbuf (
        .aclk    (aclk),
        .wr      (wr_req),
        .rd_ptr  (rd_ptr),
        .rd_data (buf_byte)
    );

    // ---------------------------------------------------------------
    // Next-state logic for one transaction.
    // Each tick is one bus quantum. A transmitted byte is 16 quanta of
    // data (SCL low/high per bit), then SDA release, an ack wait with SCL
    // high, and a final SCL-low quantum that picks the next segment.
    // ---------------------------------------------------------------
    logic [7:0] left_dec;
    logic       rx_last;
    logic [7:0] rx_shift;

    assign left_dec = (left_reg != 8'd0) ? (left_reg - 8'd1) : 8'd0;
    assign rx_last  = (left_reg <= 8'd1);
    assign rx_shift = {shift_reg[6:0], s_sda_sample};

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        bidx_next  = bidx_reg;
        addr_next  = addr_reg;
        isrd_next  = isrd_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rvalid     = 1'b0;
        rvalue     = 8'd0;
        rlast      = 1'b0;
        done       = 1'b0;

        unique case (s_func)
            i2cr16_pkg::FUNC_TICK: begin
                unique case (phase_reg)
                    i2cr16_pkg::PH_START, i2cr16_pkg::PH_RESTART: begin
                        if (cnt_reg == 5'd0) begin
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            cnt_next = 5'd1;
                        end else if (cnt_reg == 5'd1) begin
                            scl_next = 1'b1;
                            sda_next = 1'b0;
                            cnt_next = 5'd2;
                        end else begin
                            scl_next = 1'b0;
                            sda_next = 1'b0;
                            cnt_next = 5'd0;
                            // command byte is taken from its register here
                            if (phase_reg == i2cr16_pkg::PH_START) begin
                                phase_next = i2cr16_pkg::PH_TX_WCMD;
                                shift_next = wcmd_reg;
                            end else begin
                                phase_next = i2cr16_pkg::PH_TX_RCMD;
                                shift_next = rcmd_reg;
                            end
                        end
                    end
                    i2cr16_pkg::PH_TX_WCMD, i2cr16_pkg::PH_TX_AH, i2cr16_pkg::PH_TX_AL,
                    i2cr16_pkg::PH_TX_RCMD, i2cr16_pkg::PH_TX_DATA: begin
                        if (cnt_reg < 5'd16) begin
                            sda_next = shift_reg[7];
                            scl_next = cnt_reg[0];
                            if (cnt_reg[0]) begin
                                shift_next = {shift_reg[6:0], 1'b0};
                            end
                            cnt_next = cnt_reg + 5'd1;
                        end else if (cnt_reg == 5'd16) begin
                            scl_next = 1'b0;
                            sda_next = 1'b1;
                            cnt_next = 5'd17;
                        end else if (cnt_reg == 5'd17) begin
                            // ack wait: hold until the slave pulls SDA low
                            scl_next = 1'b1;
                            sda_next = 1'b1;
                            if (!s_sda_sample) begin
                                cnt_next = 5'd18;
                            end
                        end else begin
                            scl_next   = 1'b0;
                            sda_next   = 1'b1;
                            cnt_next   = 5'd0;
                            shift_next = 8'd0;
                            unique case (phase_reg)
                                i2cr16_pkg::PH_TX_WCMD: begin
                                    phase_next = i2cr16_pkg::PH_TX_AH;
                                    shift_next = addr_reg[15:8];
                                end
                                i2cr16_pkg::PH_TX_AH: begin
                                    phase_next = i2cr16_pkg::PH_TX_AL;
                                    shift_next = addr_reg[7:0];
                                end
                                i2cr16_pkg::PH_TX_AL: begin
                                    if (isrd_reg) begin
                                        phase_next = i2cr16_pkg::PH_RESTART;
                                    end else if (left_reg != 8'd0) begin
                                        phase_next = i2cr16_pkg::PH_TX_DATA;
                                        shift_next = buf_byte;
                                    end else begin
                                        phase_next = i2cr16_pkg::PH_STOP;
                                    end
                                end
                                i2cr16_pkg::PH_TX_RCMD: begin
                                    phase_next = (left_reg != 8'd0) ? i2cr16_pkg::PH_RX_DATA
                                                                    : i2cr16_pkg::PH_STOP;
                                end
                                default: begin
                                    // data byte done
                                    bidx_next = bidx_reg + BIDX_W'(1);
                                    left_next = left_dec;
                                    if (left_dec != 8'd0) begin
                                        phase_next = i2cr16_pkg::PH_TX_DATA;
                                        shift_next = buf_byte;
                                    end else begin
                                        phase_next = i2cr16_pkg::PH_STOP;
                                    end
                                end
                            endcase
                        end
                    end
                    i2cr16_pkg::PH_RX_DATA: begin
                        if (cnt_reg < 5'd16) begin
                            sda_next = 1'b1;
                            if (!cnt_reg[0]) begin
                                scl_next   = 1'b1;
                                shift_next = rx_shift;
                                if (cnt_reg == 5'd14) begin
                                    rvalid = 1'b1;
                                    rvalue = rx_shift;
                                    rlast  = rx_last;
                                end
                            end else begin
                                scl_next = 1'b0;
                            end
                            cnt_next = cnt_reg + 5'd1;
                        end else begin
                            // ack slot: drive low for more bytes, release to nack the last
                            scl_next = (cnt_reg == 5'd17);
                            sda_next = rx_last ? 1'b1 : (cnt_reg == 5'd19);
                            if (cnt_reg < (rx_last ? 5'd18 : 5'd19)) begin
                                cnt_next = cnt_reg + 5'd1;
                            end else begin
                                left_next  = left_dec;
                                cnt_next   = 5'd0;
                                shift_next = 8'd0;
                                phase_next = (left_dec != 8'd0) ? i2cr16_pkg::PH_RX_DATA
                                                                : i2cr16_pkg::PH_STOP;
                            end
                        end
                    end
                    i2cr16_pkg::PH_STOP: begin
                        if (cnt_reg == 5'd0) begin
                            scl_next = 1'b0;
                            sda_next = 1'b0;
                            cnt_next = 5'd1;
                        end else if (cnt_reg == 5'd1) begin
                            scl_next = 1'b1;
                            sda_next = 1'b0;
                            cnt_next = 5'd2;
                        end else begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            done       = 1'b1;
                            phase_next = i2cr16_pkg::PH_IDLE;
                            cnt_next   = 5'd0;
                            shift_next = 8'd0;
                        end
                    end
                    default: begin
                        // idle, and any unused code falls back to idle
                        phase_next = i2cr16_pkg::PH_IDLE;
                        cnt_next   = 5'd0;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                endcase
            end
            i2cr16_pkg::FUNC_READ, i2cr16_pkg::FUNC_WRITE: begin
                // start is ignored while a transaction is in flight
                if (phase_reg == i2cr16_pkg::PH_IDLE) begin
                    addr_next  = s_register_address;
                    isrd_next  = (s_func == i2cr16_pkg::FUNC_READ);
                    bidx_next  = '0;
                    if (s_func == i2cr16_pkg::FUNC_READ) begin
                        left_next = s_byte_count;
                    end else begin
                        left_next = (32'(s_byte_count) > BUF_DEPTH) ? 8'(BUF_DEPTH)
                                                                    : s_byte_count;
                    end
                    phase_next = i2cr16_pkg::PH_START;
                    cnt_next   = 5'd0;
                    shift_next = 8'd0;
                end
            end
            default: begin
                // load: handled by the buffer write port, lines unchanged
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= i2cr16_pkg::PH_IDLE;
            cnt_reg   <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            bidx_reg  <= '0;
            addr_reg  <= '0;
            isrd_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            bidx_reg  <= bidx_next;
            addr_reg  <= addr_next;
            isrd_reg  <= isrd_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic       scl_out_reg;
    logic       sda_out_reg;
    logic       rvalid_reg;
    logic [7:0] rvalue_reg;
    logic       rlast_reg;
    logic       busy_reg;
    logic       done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            scl_out_reg <= scl_next;
            sda_out_reg <= sda_next;
            rvalid_reg  <= rvalid;
            rvalue_reg  <= rvalue;
            rlast_reg   <= rlast;
            busy_reg    <= (phase_next != i2cr16_pkg::PH_IDLE);
            done_reg    <= done;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_scl_level        = scl_out_reg;
    assign m_sda_drive        = sda_out_reg;
    assign m_read_valid       = rvalid_reg;
    assign m_read_value       = rvalue_reg;
    assign m_read_last        = rlast_reg;
    assign m_engine_busy      = busy_reg;
    assign m_transaction_done = done_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `I2CR16_ASSERT(a_idle_cnt_zero, (phase_reg != i2cr16_pkg::PH_IDLE) || (cnt_reg == 5'd0), "bit counter not cleared in idle")
    `I2CR16_ASSERT_IMPL(a_done_not_busy, m_valid_reg && done_reg, !busy_reg, "transaction done while still busy")
    `I2CR16_ASSERT_IMPL(a_wlen_bound, (phase_reg != i2cr16_pkg::PH_IDLE) && !isrd_reg, 32'(left_reg) <= BUF_DEPTH, "write length exceeds buffer")
    `I2CR16_ASSERT_NEXT(a_stop_done, s_accept && (s_func == i2cr16_pkg::FUNC_TICK) && (phase_reg == i2cr16_pkg::PH_STOP) && (cnt_reg >= 5'd2), done_reg && !busy_reg && (phase_reg == i2cr16_pkg::PH_IDLE), "stop did not finish transaction")

endmodule
